/* hdl/assert_macros.svh */
// Assertion helpers used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at each rising edge, skip while reset is held.
`define ASSERT_SYNC(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property at each rising edge, reset cycles included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* hdl/dbio_pkg.sv */
package dbio_pkg;

    // Default counter widths
    localparam int HOLD_COUNT_BITS_DEF  = 13;
    localparam int PULSE_COUNT_BITS_DEF = 16;

    // Fixed field widths
    localparam int MODE_W     = 3;
    localparam int VALUE_W    = 16;
    localparam int DEBOUNCE_W = 13;

    // APB address and register index widths
    localparam int ADDR_W    = 5;
    localparam int REG_IDX_W = 3;
    localparam int DATA_W    = 32;

    // Item modes
    localparam logic [MODE_W-1:0] MODE_TICK    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SET     = 3'd1;
    localparam logic [MODE_W-1:0] MODE_TOGGLE  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_IMPULSE = 3'd3;
    localparam logic [MODE_W-1:0] MODE_ENABLE  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_START   = 3'd5;

    // Register indexes
    localparam logic [REG_IDX_W-1:0] REG_INPUT_INVERT    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_OUTPUT_INVERT   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_DEBOUNCE_MS     = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_DEFAULT_OUT     = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_ENABLE_AT_START = 3'd4;

    // Register reset values
    localparam logic                  RST_INPUT_INVERT    = 1'b0;
    localparam logic                  RST_OUTPUT_INVERT   = 1'b0;
    localparam logic [DEBOUNCE_W-1:0] RST_DEBOUNCE_MS     = 13'd10;
    localparam logic                  RST_DEFAULT_OUT     = 1'b0;
    localparam logic                  RST_ENABLE_AT_START = 1'b1;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic               pin_sample;
        logic [VALUE_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic pin_drive;
        logic out_level;
        logic input_level;
        logic report_valid;
        logic enabled;
    } t_out_item;

    typedef struct packed {
        logic                  input_invert;
        logic                  output_invert;
        logic [DEBOUNCE_W-1:0] debounce_ms;
        logic                  default_out;
        logic                  enable_at_start;
    } t_cfg;

endpackage

/* hdl/debounced_io_with_pulse_output_top.sv */
// One digital I/O channel: debounced input plus a driven output with timed pulses.
// Input channel (i_in_valid / o_in_ready / i_in_item) carries one transaction per
// millisecond tick or command; mode selects tick, set level, toggle, impulse,
// enable or start. Output channel (o_out_valid / i_out_ready / o_out_item) returns
// exactly one result per input transaction, in order.
// An accepted transaction is held in the input register; the channel logic then
// loads its result into the result register, which drives o_out_valid.
// Throughput: one transaction per cycle while the receiver does not stall.
// The input register keeps taking a transaction while a result waits at the
// output; when the receiver stalls and both registers are full, o_in_ready drops.
// Reset (synchronous, active low) empties both registers, loads the register
// defaults (debounce 10 ticks, channel enabled, default output low) and clears
// the debounce and pulse counters.
// Registers sit on an APB port at byte addresses 0, 4, 8, 12, 16; pready is
// always high. Write them only while no transaction is in flight.
`include "assert_macros.svh"

module debounced_io_with_pulse_output_top #(
    parameter int HOLD_COUNT_BITS  = dbio_pkg::HOLD_COUNT_BITS_DEF,
    parameter int PULSE_COUNT_BITS = dbio_pkg::PULSE_COUNT_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  dbio_pkg::t_in_item            i_in_item,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output dbio_pkg::t_out_item           o_out_item,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dbio_pkg::ADDR_W-1:0]   paddr,
    input  logic [dbio_pkg::DATA_W-1:0]   pwdata,
    output logic [dbio_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);

    dbio_pkg::t_cfg      r_cfg;
    logic                r_in_valid;
    dbio_pkg::t_in_item  r_in_item;
    logic                r_out_valid;
    dbio_pkg::t_out_item r_out_item;
    dbio_pkg::t_out_item w_result;
    logic                w_advance;
    logic                w_fire;
    logic                w_cfg_wr;
    logic [dbio_pkg::REG_IDX_W-1:0] w_reg_idx;

    // Handshake between the input and result registers
    assign w_advance   = !r_out_valid || i_out_ready;
    assign w_fire      = r_in_valid && w_advance;
    assign o_in_ready  = !r_in_valid || w_advance;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // Register port decode
    assign pready    = 1'b1;
    assign w_reg_idx = paddr[dbio_pkg::ADDR_W-1:2];
    assign w_cfg_wr  = psel && penable && pwrite;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.input_invert    <= dbio_pkg::RST_INPUT_INVERT;
            r_cfg.output_invert   <= dbio_pkg::RST_OUTPUT_INVERT;
            r_cfg.debounce_ms     <= dbio_pkg::RST_DEBOUNCE_MS;
            r_cfg.default_out     <= dbio_pkg::RST_DEFAULT_OUT;
            r_cfg.enable_at_start <= dbio_pkg::RST_ENABLE_AT_START;
        end else if (w_cfg_wr) begin
            unique case (w_reg_idx)
                dbio_pkg::REG_INPUT_INVERT:    r_cfg.input_invert    <= pwdata[0];
                dbio_pkg::REG_OUTPUT_INVERT:   r_cfg.output_invert   <= pwdata[0];
                dbio_pkg::REG_DEBOUNCE_MS:
                    r_cfg.debounce_ms <= pwdata[dbio_pkg::DEBOUNCE_W-1:0];
                dbio_pkg::REG_DEFAULT_OUT:     r_cfg.default_out     <= pwdata[0];
                dbio_pkg::REG_ENABLE_AT_START: r_cfg.enable_at_start <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    // Read back configuration registers
    always_comb begin
        unique case (w_reg_idx)
            dbio_pkg::REG_INPUT_INVERT:    prdata = dbio_pkg::DATA_W'(r_cfg.input_invert);
            dbio_pkg::REG_OUTPUT_INVERT:   prdata = dbio_pkg::DATA_W'(r_cfg.output_invert);
            dbio_pkg::REG_DEBOUNCE_MS:     prdata = dbio_pkg::DATA_W'(r_cfg.debounce_ms);
            dbio_pkg::REG_DEFAULT_OUT:     prdata = dbio_pkg::DATA_W'(r_cfg.default_out);
            dbio_pkg::REG_ENABLE_AT_START: prdata = dbio_pkg::DATA_W'(r_cfg.enable_at_start);
            default:                       prdata = '0;
        endcase
    end

    // Hold the accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_item <= i_in_item;
        end
    end

    dbio_chan #(
        .HOLD_COUNT_BITS  (HOLD_COUNT_BITS),
        .PULSE_COUNT_BITS (PULSE_COUNT_BITS)
    ) u_chan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_fire),
        .i_item   (r_in_item),
        .i_cfg    (r_cfg),
        .o_result (w_result)
    );

    // Capture the result and hold it until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_item <= w_result;
        end
    end

    `ASSERT_SYNC(a_fire_fills_out, i_clk, i_rst_n, w_fire |=> r_out_valid, "result lost after transaction")
    `ASSERT_SYNC(a_report_needs_enable, i_clk, i_rst_n, (r_out_valid && r_out_item.report_valid) |-> r_out_item.enabled, "report while disabled")
    `ASSERT_SYNC(a_full_stall_blocks, i_clk, i_rst_n, (r_in_valid && r_out_valid && !i_out_ready) |=> ($stable(r_in_item) && r_in_valid), "input register overwritten during stall")
    `ASSERT_ALWAYS(a_reset_empties, i_clk, !i_rst_n |=> (!r_out_valid && !r_in_valid), "registers not empty after reset")

endmodule

/* hdl/dbio_chan.sv */
module dbio_chan #(
    parameter int HOLD_COUNT_BITS  = dbio_pkg::HOLD_COUNT_BITS_DEF,
    parameter int PULSE_COUNT_BITS = dbio_pkg::PULSE_COUNT_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  dbio_pkg::t_in_item  i_item,
    input  dbio_pkg::t_cfg      i_cfg,
    output dbio_pkg::t_out_item o_result
);

    localparam int CMP_W = (HOLD_COUNT_BITS > dbio_pkg::DEBOUNCE_W) ?
                           HOLD_COUNT_BITS : dbio_pkg::DEBOUNCE_W;
    localparam int LEN_W = (PULSE_COUNT_BITS > dbio_pkg::VALUE_W) ?
                           PULSE_COUNT_BITS : dbio_pkg::VALUE_W;
    localparam logic [HOLD_COUNT_BITS-1:0]  HOLD_MAX  = '1;
    localparam logic [PULSE_COUNT_BITS-1:0] PULSE_MAX = '1;

    logic                        r_acc,      n_acc;
    logic                        r_pend,     n_pend;
    logic [HOLD_COUNT_BITS-1:0]  r_held,     n_held;
    logic                        r_drive,    n_drive;
    logic                        r_pulse_on, n_pulse_on;
    logic                        r_rest,     n_rest;
    logic [PULSE_COUNT_BITS-1:0] r_left,     n_left;
    logic                        r_on,       n_on;
    logic                        n_report;

    logic                        w_raw;
    logic                        w_value_nz;
    logic [LEN_W-1:0]            w_len_ext;
    logic [PULSE_COUNT_BITS-1:0] w_len;

    // Condition the sample and clamp the impulse length
    always_comb begin
        w_raw      = i_item.pin_sample ^ i_cfg.input_invert;
        w_value_nz = (i_item.value != '0);
        w_len_ext  = LEN_W'(i_item.value);
        if (w_len_ext > LEN_W'(PULSE_MAX)) begin
            w_len_ext = LEN_W'(PULSE_MAX);
        end
        w_len = PULSE_COUNT_BITS'(w_len_ext);
        if (w_len == '0) begin
            w_len = PULSE_COUNT_BITS'(1);
        end
    end

    // Next state and report for the current transaction
    always_comb begin
        n_acc      = r_acc;
        n_pend     = r_pend;
        n_held     = r_held;
        n_drive    = r_drive;
        n_pulse_on = r_pulse_on;
        n_rest     = r_rest;
        n_left     = r_left;
        n_on       = r_on;
        n_report   = 1'b0;
        unique case (i_item.mode)
            dbio_pkg::MODE_TICK: begin
                // restart the hold count on a change, else count up and saturate
                if (w_raw != r_pend) begin
                    n_pend = w_raw;
                    n_held = '0;
                end else if (r_held != HOLD_MAX) begin
                    n_held = r_held + HOLD_COUNT_BITS'(1);
                end
                if ((n_pend != r_acc) &&
                    (CMP_W'(n_held) >= CMP_W'(i_cfg.debounce_ms))) begin
                    n_acc    = n_pend;
                    n_report = r_on;
                end
                // count the pulse down and drop back to rest at expiry
                if (r_pulse_on) begin
                    if (r_left != '0) begin
                        n_left = r_left - PULSE_COUNT_BITS'(1);
                    end
                    if (n_left == '0) begin
                        n_pulse_on = 1'b0;
                        n_drive    = r_rest;
                    end
                end
            end
            dbio_pkg::MODE_SET: begin
                if (r_on) begin
                    n_drive = w_value_nz;
                end
            end
            dbio_pkg::MODE_TOGGLE: begin
                if (r_on) begin
                    n_drive = ~r_drive;
                end
            end
            dbio_pkg::MODE_IMPULSE: begin
                // a repeated impulse keeps the first rest level
                if (r_on) begin
                    if (!r_pulse_on) begin
                        n_rest     = r_drive;
                        n_pulse_on = 1'b1;
                        n_drive    = ~r_drive;
                    end else begin
                        n_drive = ~r_rest;
                    end
                    n_left = w_len;
                end
            end
            dbio_pkg::MODE_ENABLE: begin
                n_on = w_value_nz;
                if (!w_value_nz) begin
                    n_pulse_on = 1'b0;
                    n_left     = '0;
                    n_drive    = i_cfg.default_out;
                end
            end
            dbio_pkg::MODE_START: begin
                n_acc      = w_raw;
                n_pend     = w_raw;
                n_held     = '0;
                n_pulse_on = 1'b0;
                n_left     = '0;
                n_rest     = 1'b0;
                n_drive    = i_cfg.default_out;
                n_on       = i_cfg.enable_at_start;
                n_report   = i_cfg.enable_at_start;
            end
            default: begin
            end
        endcase
    end

    // Build the result from the updated state
    always_comb begin
        o_result.pin_drive    = n_drive ^ i_cfg.output_invert;
        o_result.out_level    = n_drive;
        o_result.input_level  = n_acc;
        o_result.report_valid = n_report;
        o_result.enabled      = n_on;
    end

    // Advance channel state on each transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc      <= 1'b0;
            r_pend     <= 1'b0;
            r_held     <= '0;
            r_drive    <= dbio_pkg::RST_DEFAULT_OUT;
            r_pulse_on <= 1'b0;
            r_rest     <= 1'b0;
            r_left     <= '0;
            r_on       <= dbio_pkg::RST_ENABLE_AT_START;
        end else if (i_fire) begin
            r_acc      <= n_acc;
            r_pend     <= n_pend;
            r_held     <= n_held;
            r_drive    <= n_drive;
            r_pulse_on <= n_pulse_on;
            r_rest     <= n_rest;
            r_left     <= n_left;
            r_on       <= n_on;
        end
    end

endmodule

/* tb/debounced_io_with_pulse_output_top_test.sv */
`timescale 1ns / 100ps

module debounced_io_with_pulse_output_top_test;
    import dbio_pkg::*;

    // Unused mode codes, expected to pass through without effect
    localparam logic [MODE_W-1:0] MODE_SPARE_A = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE_B = 3'd7;

    localparam logic [DEBOUNCE_W-1:0] HOLD_MAX = '1;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_ready;
    t_in_item            i_in_item = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    t_out_item           o_out_item;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [ADDR_W-1:0]   paddr = '0;
    logic [DATA_W-1:0]   pwdata = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    // Register shadow and channel state for the expected results
    t_cfg                cfg_now;
    logic                acc_lvl;
    logic                pend_lvl;
    logic [DEBOUNCE_W-1:0] hold_cnt;
    logic                drv_lvl;
    logic                pulse_on;
    logic                rest_lvl;
    logic [VALUE_W-1:0]  pulse_cnt;
    logic                chan_on;

    t_out_item           channel_results_q[$];
    int                  fail_count = 0;
    int                  idle_pct = 38;
    logic                pin_now = 1'b0;

    debounced_io_with_pulse_output_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Stall the receiver at random
    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= idle_pct);
    end

    // Advance the channel state by one item and return its result
    function automatic t_out_item compute_channel_result(t_in_item itm);
        logic      raw;
        logic      report;
        t_out_item res;
        raw = itm.pin_sample ^ cfg_now.input_invert;
        report = 1'b0;
        case (itm.mode)
            MODE_TICK: begin
                if (raw != pend_lvl) begin
                    pend_lvl = raw;
                    hold_cnt = '0;
                end else if (hold_cnt != HOLD_MAX) begin
                    hold_cnt = hold_cnt + 1'b1;
                end
                if (pend_lvl != acc_lvl && hold_cnt >= cfg_now.debounce_ms) begin
                    acc_lvl = pend_lvl;
                    report = chan_on;
                end
                if (pulse_on) begin
                    if (pulse_cnt != 0)
                        pulse_cnt = pulse_cnt - 1'b1;
                    if (pulse_cnt == 0) begin
                        pulse_on = 1'b0;
                        drv_lvl = rest_lvl;
                    end
                end
            end
            MODE_SET: begin
                if (chan_on)
                    drv_lvl = (itm.value != 0);
            end
            MODE_TOGGLE: begin
                if (chan_on)
                    drv_lvl = ~drv_lvl;
            end
            MODE_IMPULSE: begin
                if (chan_on) begin
                    if (!pulse_on) begin
                        rest_lvl = drv_lvl;
                        pulse_on = 1'b1;
                    end
                    drv_lvl = ~rest_lvl;
                    // zero length counts as one tick
                    pulse_cnt = (itm.value == 0) ? VALUE_W'(1) : itm.value;
                end
            end
            MODE_ENABLE: begin
                chan_on = (itm.value != 0);
                if (!chan_on) begin
                    pulse_on = 1'b0;
                    pulse_cnt = '0;
                    drv_lvl = cfg_now.default_out;
                end
            end
            MODE_START: begin
                acc_lvl = raw;
                pend_lvl = raw;
                hold_cnt = '0;
                pulse_on = 1'b0;
                pulse_cnt = '0;
                rest_lvl = 1'b0;
                drv_lvl = cfg_now.default_out;
                chan_on = cfg_now.enable_at_start;
                report = chan_on;
            end
            default: ;
        endcase
        res.pin_drive = drv_lvl ^ cfg_now.output_invert;
        res.out_level = drv_lvl;
        res.input_level = acc_lvl;
        res.report_valid = report;
        res.enabled = chan_on;
        return res;
    endfunction

    task automatic report_mismatch(string msg);
        fail_count++;
        $display("ERROR at %0t ns: %s", $time, msg);
    endtask

    task automatic check_field(string name, logic got, logic exp);
        if (got !== exp)
            report_mismatch($sformatf("%s is %b, expected %b", name, got, exp));
    endtask

    // Compare each result transaction with the oldest expectation
    always @(posedge i_clk) begin : check_results
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (channel_results_q.size() == 0) begin
                report_mismatch("result transaction with nothing expected");
            end else begin
                want = channel_results_q.pop_front();
                check_field("pin_drive", o_out_item.pin_drive, want.pin_drive);
                check_field("out_level", o_out_item.out_level, want.out_level);
                check_field("input_level", o_out_item.input_level, want.input_level);
                check_field("report_valid", o_out_item.report_valid, want.report_valid);
                check_field("enabled", o_out_item.enabled, want.enabled);
            end
        end
    end

    function automatic t_in_item make_item(logic [MODE_W-1:0] mode, logic pin,
                                           logic [VALUE_W-1:0] val);
        t_in_item itm;
        itm.mode = mode;
        itm.pin_sample = pin;
        itm.value = val;
        return itm;
    endfunction

    // Present one transaction, hold it until accepted, then record its result
    task automatic send_item(t_in_item itm);
        @(negedge i_clk);
        if ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item <= itm;
        do @(posedge i_clk); while (!o_in_ready);
        channel_results_q.push_back(compute_channel_result(itm));
    endtask

    // Drop valid and hold off until every result has come back
    task automatic wait_drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (channel_results_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // APB write: setup cycle, then access cycle until pready
    task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_INPUT_INVERT:    cfg_now.input_invert = data[0];
            REG_OUTPUT_INVERT:   cfg_now.output_invert = data[0];
            REG_DEBOUNCE_MS:     cfg_now.debounce_ms = data[DEBOUNCE_W-1:0];
            REG_DEFAULT_OUT:     cfg_now.default_out = data[0];
            REG_ENABLE_AT_START: cfg_now.enable_at_start = data[0];
            default: ;
        endcase
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic apply_settings(logic in_inv, logic out_inv, int debounce,
                                  logic dflt, logic en_start);
        write_reg(REG_INPUT_INVERT, DATA_W'(in_inv));
        write_reg(REG_OUTPUT_INVERT, DATA_W'(out_inv));
        write_reg(REG_DEBOUNCE_MS, DATA_W'(debounce));
        write_reg(REG_DEFAULT_OUT, DATA_W'(dflt));
        write_reg(REG_ENABLE_AT_START, DATA_W'(en_start));
    endtask

    // Mostly ticks on a slowly changing pin with rare glitches, plus commands
    function automatic t_in_item random_item();
        int                 r;
        int                 sel;
        logic [VALUE_W-1:0] v;
        logic               pin;
        r = $urandom_range(99);
        v = VALUE_W'($urandom);
        pin = 1'($urandom);
        if (r < 60) begin
            if ($urandom_range(7) == 0)
                pin_now = ~pin_now;
            pin = ($urandom_range(15) == 0) ? ~pin_now : pin_now;
            return make_item(MODE_TICK, pin, v);
        end else if (r < 68) begin
            return make_item(MODE_SET, pin, ($urandom_range(3) == 0) ? '0 : v);
        end else if (r < 76) begin
            return make_item(MODE_TOGGLE, pin, v);
        end else if (r < 86) begin
            sel = $urandom_range(9);
            if (sel == 0)
                v = '0;
            else if (sel > 1)
                v = VALUE_W'($urandom_range(1, 8));
            return make_item(MODE_IMPULSE, pin, v);
        end else if (r < 92) begin
            return make_item(MODE_ENABLE, pin, ($urandom_range(3) == 0) ? '0 : v);
        end else if (r < 96) begin
            return make_item(MODE_START, pin, v);
        end
        return make_item(($urandom_range(1) == 0) ? MODE_SPARE_A : MODE_SPARE_B, pin, v);
    endfunction

    function automatic t_in_item random_tick();
        if ($urandom_range(5) == 0)
            pin_now = ~pin_now;
        return make_item(MODE_TICK, pin_now, VALUE_W'($urandom));
    endfunction

    // Every mode, field extremes, zero debounce, pulse corner cases, disabled channel
    task automatic test_directed();
        apply_settings(1'b0, 1'b0, 0, 1'b0, 1'b1);
        send_item(make_item(MODE_START, 1'b1, 16'h0000));
        send_item(make_item(MODE_TICK, 1'b0, 16'hFFFF));
        send_item(make_item(MODE_TICK, 1'b0, 16'h0000));
        send_item(make_item(MODE_SET, 1'b0, 16'hFFFF));
        send_item(make_item(MODE_SET, 1'b1, 16'h0000));
        send_item(make_item(MODE_TOGGLE, 1'b0, 16'h0000));
        send_item(make_item(MODE_IMPULSE, 1'b0, 16'h0000));
        send_item(make_item(MODE_TICK, 1'b0, 16'h0000));
        send_item(make_item(MODE_IMPULSE, 1'b0, 16'd3));
        send_item(make_item(MODE_IMPULSE, 1'b0, 16'hFFFF));
        send_item(make_item(MODE_TOGGLE, 1'b0, 16'h0000));
        send_item(make_item(MODE_TICK, 1'b0, 16'h0000));
        send_item(make_item(MODE_ENABLE, 1'b0, 16'h0000));
        send_item(make_item(MODE_SET, 1'b0, 16'h0001));
        send_item(make_item(MODE_TOGGLE, 1'b0, 16'h0000));
        send_item(make_item(MODE_IMPULSE, 1'b0, 16'd5));
        send_item(make_item(MODE_TICK, 1'b1, 16'h0000));
        send_item(make_item(MODE_ENABLE, 1'b0, 16'h8000));
        send_item(make_item(MODE_SPARE_A, 1'b0, 16'h0000));
        send_item(make_item(MODE_SPARE_B, 1'b1, 16'hFFFF));
        wait_drain();
        write_reg(REG_DEBOUNCE_MS, DATA_W'(2));
        send_item(make_item(MODE_TICK, 1'b0, 16'h0000));
        send_item(make_item(MODE_TICK, 1'b0, 16'h0000));
        send_item(make_item(MODE_TICK, 1'b0, 16'h0000));
        send_item(make_item(MODE_IMPULSE, 1'b0, 16'd2));
        send_item(make_item(MODE_TICK, 1'b0, 16'h0000));
        send_item(make_item(MODE_TICK, 1'b0, 16'h0000));
        wait_drain();
    endtask

    // Impulses each followed by at least as many items as the pulse length, mostly ticks, with retriggers and overrides
    task automatic test_pulse_sequences();
        int                 len;
        int                 n;
        logic [VALUE_W-1:0] v;
        apply_settings(1'b0, 1'b1, 2, 1'b1, 1'b1);
        send_item(make_item(MODE_START, 1'b0, 16'h0000));
        repeat (40) begin
            len = $urandom_range(0, 6);
            send_item(make_item(MODE_IMPULSE, 1'($urandom), VALUE_W'(len)));
            n = len + $urandom_range(0, 2);
            repeat (n) begin
                v = VALUE_W'($urandom);
                case ($urandom_range(9))
                    0: send_item(make_item(MODE_SET, 1'($urandom), v));
                    1: send_item(make_item(MODE_TOGGLE, 1'($urandom), v));
                    2: send_item(make_item(MODE_IMPULSE, 1'($urandom),
                                           VALUE_W'($urandom_range(1, 4))));
                    default: send_item(random_tick());
                endcase
            end
        end
        wait_drain();
    endtask

    // Long debounce, run without any idling on either side
    task automatic test_long_hold();
        apply_settings(1'b1, 1'b0, 1000, 1'b0, 1'b1);
        idle_pct = 0;
        send_item(make_item(MODE_START, 1'b1, 16'h0000));
        send_item(make_item(MODE_IMPULSE, 1'b0, 16'hFFFF));
        repeat (1004) send_item(make_item(MODE_TICK, 1'b0, VALUE_W'($urandom)));
        send_item(make_item(MODE_ENABLE, 1'b0, 16'h0000));
        wait_drain();
        idle_pct = 38;
    endtask

    // Random traffic under several register settings, extremes included
    task automatic test_settings_sweep();
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: apply_settings(1'b0, 1'b0, 1, 1'b0, 1'b1);
                1: apply_settings(1'b1, 1'b1, 0, 1'b1, 1'b0);
                2: apply_settings(1'b1, 1'b0, 3, 1'b1, 1'b1);
                3: apply_settings(1'($urandom), 1'b1, $urandom_range(1, 12),
                                  1'($urandom), 1'($urandom));
                default: apply_settings(1'($urandom), 1'($urandom), $urandom_range(2, 6),
                                        1'($urandom), 1'b1);
            endcase
            send_item(make_item(MODE_START, 1'($urandom), VALUE_W'($urandom)));
            repeat (80) send_item(random_item());
            wait_drain();
        end
    endtask

    initial begin
        cfg_now.input_invert = RST_INPUT_INVERT;
        cfg_now.output_invert = RST_OUTPUT_INVERT;
        cfg_now.debounce_ms = RST_DEBOUNCE_MS;
        cfg_now.default_out = RST_DEFAULT_OUT;
        cfg_now.enable_at_start = RST_ENABLE_AT_START;
        acc_lvl = 1'b0;
        pend_lvl = 1'b0;
        hold_cnt = '0;
        drv_lvl = RST_DEFAULT_OUT;
        pulse_on = 1'b0;
        rest_lvl = 1'b0;
        pulse_cnt = '0;
        chan_on = RST_ENABLE_AT_START;

        // Hold reset, then release it
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_pulse_sequences();
        test_long_hold();
        test_settings_sweep();
        wait_drain();

        if (fail_count == 0)
            $display("debounced_io_with_pulse_output_top: match");
        else
            $display("debounced_io_with_pulse_output_top: mismatch");
        $finish;
    end

    // Stop a hung run
    initial begin
        #5_000_000;
        $display("debounced_io_with_pulse_output_top: mismatch");
        $finish;
    end

endmodule
